// File: design/exsort_pkg.sv
// shared constants and controller/datapath interface types for the exchange sort engine
package exsort_pkg;

    // store capacity and derived widths
    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // commands from controller to datapath
    typedef struct packed {
        logic in_take;      // input item accepted this cycle
        logic rd_en;        // issue a store read
        idx_t rd_addr;
        logic pivot_load;   // capture read data as row pivot
        logic scan_en;      // read data holds the scanned column entry
        idx_t scan_addr;
        logic scan_self;    // scanned column is the pivot row itself
        logic row_wr;       // write pivot back to its row
        idx_t row_addr;
        logic out_load;     // move read data into the output register
        logic out_last;     // loaded item is the final one of the batch
    } exsort_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        cnt_t count;        // stored elements in this batch
        logic out_free;     // output register can take an item now
    } exsort_sts_t;

endpackage

// File: design/exchange_sort_engine.sv
// top level of the exchange sort engine: controller plus datapath
//
//  channel  dir  handshake         tdata                 side band
//  s_       in   s_tvalid/s_tready [31:0] value          s_tlast = is_last
//  m_       out  m_tvalid/m_tready [31:0] sorted_value   m_tlast = is_last_res,
//                                                        m_tuser = dropped
//
// loading takes one item per cycle; a batch of n stored elements is then sorted
// row by row by one comparator working through the single store read port
// results follow one at a time, each one read from the store
// reset (aresetn low, synchronous) empties the batch and clears the output register
// the next batch loads while the final result of a batch still waits on m_tready
// a stall on m_tready holds the readout; s_tready stays low from the last item to
// the final result
module exchange_sort_engine
    import exsort_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic              m_tlast,
    output logic              m_tuser    // [0] dropped
);

    exsort_cmd_t cmd;
    exsort_sts_t sts;

    // sequencer
    exsort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, compare-and-swap and output
    exsort_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: design/exsort_ctrl.sv
// controller state machine: load, row by row exchange sort, and result readout
module exsort_ctrl
    import exsort_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  exsort_sts_t sts,
    output exsort_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW_START,
        ST_ROW_PIVOT,
        ST_SCAN,
        ST_ROW_END,
        ST_OUT_READ,
        ST_OUT_LOAD
    } state_t;

    state_t state_reg, state_next;
    idx_t   row_reg, row_next;
    idx_t   col_reg, col_next;
    logic   col_end;
    logic   row_end;

    // end of column scan and of the row sweep, against the batch size
    assign col_end = ((CNT_W'(col_reg) + CNT_W'(1)) == sts.count);
    assign row_end = ((CNT_W'(row_reg) + CNT_W'(1)) == sts.count);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready    = 1'b1;
                cmd.in_take = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    row_next   = '0;
                    state_next = ST_ROW_START;
                end
            end
            ST_ROW_START: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = row_reg;
                state_next  = ST_ROW_PIVOT;
            end
            ST_ROW_PIVOT: begin
                cmd.pivot_load = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_addr    = '0;
                col_next       = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_en   = 1'b1;
                cmd.scan_addr = col_reg;
                cmd.scan_self = (col_reg == row_reg);
                if (col_end) begin
                    state_next = ST_ROW_END;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = col_reg + idx_t'(1);
                    col_next    = col_reg + idx_t'(1);
                end
            end
            ST_ROW_END: begin
                cmd.row_wr   = 1'b1;
                cmd.row_addr = row_reg;
                if (row_end) begin
                    col_next   = '0;
                    state_next = ST_OUT_READ;
                end else begin
                    row_next   = row_reg + idx_t'(1);
                    state_next = ST_ROW_START;
                end
            end
            ST_OUT_READ: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = col_reg;
                state_next  = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = col_end;
                    if (col_end) begin
                        state_next = ST_LOAD;
                    end else begin
                        col_next   = col_reg + idx_t'(1);
                        state_next = ST_OUT_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

// File: design/exsort_dp.sv
// datapath: element store, pivot register with comparator, batch counter and overflow flag, output register
module exsort_dp
    import exsort_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DATA_W-1:0] s_tdata,
    input  exsort_cmd_t       cmd,
    output exsort_sts_t       sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    elem_t store_mem [MAX_ITEMS];
    elem_t rd_data_reg;
    elem_t pivot_reg, pivot_next;
    cnt_t  count_reg, count_next;
    logic  overflow_reg, overflow_next;
    logic  room;
    logic  swap;
    logic  wr_en;
    idx_t  wr_addr;
    elem_t wr_data;

    logic  out_valid_reg;
    elem_t out_data_reg;
    logic  out_last_reg;
    logic  out_drop_reg;

    assign room = (count_reg < CNT_W'(MAX_ITEMS));

    // swap when the pivot row entry is less than the scanned column entry
    assign swap = cmd.scan_en && !cmd.scan_self && (pivot_reg < rd_data_reg);

    // single write port shared by load, swap and row write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = pivot_reg;
        if (cmd.in_take && room) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = elem_t'(s_tdata);
        end else if (swap) begin
            wr_en   = 1'b1;
            wr_addr = cmd.scan_addr;
        end else if (cmd.row_wr) begin
            wr_en   = 1'b1;
            wr_addr = cmd.row_addr;
        end
    end

    // element store with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[cmd.rd_addr];
        end
    end

    // pivot and batch bookkeeping
    always_comb begin
        pivot_next    = pivot_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.pivot_load || swap) begin
            pivot_next = rd_data_reg;
        end
        if (cmd.in_take) begin
            if (room) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.out_load && cmd.out_last) begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        pivot_reg <= pivot_next;
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= cmd.out_last;
            out_drop_reg <= overflow_reg;
        end
    end

    assign sts.count    = count_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

endmodule

// File: design/exsort_checker.sv
// port-level checks for the exchange sort engine, bound to the top level
module exsort_checker
    import exsort_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item valid after reset");

    // a stalled result item holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result item changed");

    // the last item of a batch closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after last item");

    // no input is taken while a batch is still being emitted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input open during batch readout");

    // the dropped flag is the same on every item of a batch
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
        else $error("dropped flag changed within a batch");

endmodule

bind exchange_sort_engine exsort_checker u_exsort_checker (.*);
